### hdl/hmp_pkg.sv
// hmp_pkg: request, result, state and configuration types of the hoist motion profiler,
// together with the request, direction, phase and register index codes.
// No dependencies; every other file of the block imports it.
package hmp_pkg;

    // request codes
    localparam logic [1:0] REQ_GOTO    = 2'd0;
    localparam logic [1:0] REQ_STOP    = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;
    localparam logic [1:0] REQ_RELEVEL = 2'd3;

    // direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // phase codes
    localparam logic [1:0] PHASE_NONE    = 2'd0;
    localparam logic [1:0] PHASE_MOVING  = 2'd1;
    localparam logic [1:0] PHASE_SLOWING = 2'd2;
    localparam logic [1:0] PHASE_LEVEL   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CREEP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW      = 3'd6;
    localparam int CFG_DATA_W = 12;

    // register reset values
    localparam logic [11:0] RST_FLOOR0    = 12'd0;
    localparam logic [11:0] RST_FLOOR1    = 12'd300;
    localparam logic [11:0] RST_FLOOR2    = 12'd600;
    localparam logic [11:0] RST_FLOOR3    = 12'd900;
    localparam logic [7:0]  RST_TOLERANCE = 8'd3;
    localparam logic [7:0]  RST_CREEP     = 8'd15;
    localparam logic [9:0]  RST_SLOW      = 10'd60;

    // duty levels and limits
    localparam logic [6:0] DUTY_ZERO  = 7'd0;
    localparam logic [6:0] DUTY_CREEP = 7'd15;
    localparam logic [6:0] DUTY_SLOW  = 7'd30;
    localparam logic [6:0] DUTY_FULL  = 7'd100;
    localparam logic [2:0] TOP_FLOOR  = 3'd3;
    localparam logic [1:0] TRIES_MAX  = 2'd3;
    localparam logic [1:0] TRIES_FAIL = 2'd2;

    typedef struct packed {
        logic [3:0][11:0] floor_h;
        logic [7:0]       tolerance;
        logic [7:0]       creep_band;
        logic [9:0]       slow_band;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  target_floor;
        logic [11:0] position_cm;
        logic        fault_present;
    } t_req;

    typedef struct packed {
        logic        armed;
        logic [11:0] target_height;
        logic [5:0]  ramp_count;
        logic [1:0]  relevel_tries;
        logic [6:0]  last_duty;
        logic [1:0]  last_direction;
        logic        level_flag;
    } t_state;

    typedef struct packed {
        logic       rejected;
        logic [6:0] duty_pct;
        logic [1:0] direction;
        logic       levelled;
        logic [1:0] phase;
        logic       brake;
        logic       level_fail;
        logic       motion_active;
        logic       at_target;
    } t_result;

endpackage

### hdl/hoist_motion_profile.sv
// hoist_motion_profile: lift hoist motion profiler, one request item in, one result item out.
// Items pass the input register, then the result register; both hold while a result waits on i_out_ready.
// One item per cycle unless held; the profile state updates as an item leaves the input register.
// Reset (i_rst_n low, synchronous): pipeline empty, motion disarmed, counters and duty cleared,
// configuration registers back to their default floor heights and bands.
// Depends on hmp_pkg, hmp_cfg and hmp_step.
module hoist_motion_profile
    import hmp_pkg::*;
#(
    parameter int RAMP_TICKS = 50
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [2:0]            i_target_floor,
    input  logic [11:0]           i_position_cm,
    input  logic                  i_fault_present,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_rejected,
    output logic [6:0]            o_duty_pct,
    output logic [1:0]            o_direction,
    output logic                  o_levelled,
    output logic [1:0]            o_phase,
    output logic                  o_brake,
    output logic                  o_level_fail,
    output logic                  o_motion_active,
    output logic                  o_at_target,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    logic    r_in_valid;
    t_req    r_in;
    t_state  r_state;
    t_state  n_state;
    t_result step_res;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    hmp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // handshake: the item in the input register moves on whenever the result slot frees
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.req_type      <= i_req_type;
            r_in.target_floor  <= i_target_floor;
            r_in.position_cm   <= i_position_cm;
            r_in.fault_present <= i_fault_present;
        end
    end

    // request logic
    hmp_step #(
        .RAMP_TICKS (RAMP_TICKS)
    ) u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_req    (r_in),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // profile state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rejected      = r_out.rejected;
    assign o_duty_pct      = r_out.duty_pct;
    assign o_direction     = r_out.direction;
    assign o_levelled      = r_out.levelled;
    assign o_phase         = r_out.phase;
    assign o_brake         = r_out.brake;
    assign o_level_fail    = r_out.level_fail;
    assign o_motion_active = r_out.motion_active;
    assign o_at_target     = r_out.at_target;

    // a level-fail result always brakes and leaves the motion disarmed
    a_fail_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_level_fail) |-> (o_brake && !o_motion_active))
        else $error("level fail without brake or with motion armed");

    // a rejected goto never brakes and sets no phase
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (!o_brake && (o_phase == PHASE_NONE)))
        else $error("rejected goto changed motion");

    // a stop leaving the input register disarms the profile
    a_stop_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.req_type == REQ_STOP))
        |=> (!r_state.armed && r_state.ramp_count == 6'd0))
        else $error("stop did not disarm");

    // a new result only appears when an item moved out of the input register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && o_out_valid && i_out_ready) |=> !o_out_valid)
        else $error("result item without a request item");

endmodule

### hdl/hmp_cfg.sv
// hmp_cfg: configuration register file of the hoist motion profiler (floor heights, bands).
// Depends on hmp_pkg for the register indexes, reset values and t_cfg.
module hmp_cfg
    import hmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // write decode, indexes past the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_FLOOR0:    n_cfg.floor_h[0]  = i_wr_data;
                CFG_FLOOR1:    n_cfg.floor_h[1]  = i_wr_data;
                CFG_FLOOR2:    n_cfg.floor_h[2]  = i_wr_data;
                CFG_FLOOR3:    n_cfg.floor_h[3]  = i_wr_data;
                CFG_TOLERANCE: n_cfg.tolerance   = i_wr_data[7:0];
                CFG_CREEP:     n_cfg.creep_band  = i_wr_data[7:0];
                CFG_SLOW:      n_cfg.slow_band   = i_wr_data[9:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_h[0] <= RST_FLOOR0;
            r_cfg.floor_h[1] <= RST_FLOOR1;
            r_cfg.floor_h[2] <= RST_FLOOR2;
            r_cfg.floor_h[3] <= RST_FLOOR3;
            r_cfg.tolerance  <= RST_TOLERANCE;
            r_cfg.creep_band <= RST_CREEP;
            r_cfg.slow_band  <= RST_SLOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/hmp_step.sv
// hmp_step: next-state and result logic for one request of the hoist motion profiler.
// Purely combinational; depends on hmp_pkg for types and codes.
module hmp_step
    import hmp_pkg::*;
#(
    parameter int RAMP_TICKS = 50
)
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_req    i_req,
    output t_state  o_state,
    output t_result o_result
);

    // ramp duty = count * 100 / RAMP_TICKS by reciprocal multiply, exact for counts up to 63
    localparam int          RECIP_SH = 16;
    localparam int          RECIP_W  = 24;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'((100 * (2 ** RECIP_SH) + RAMP_TICKS - 1) / RAMP_TICKS);
    localparam logic [5:0]  RAMP_LIM = 6'(RAMP_TICKS);

    logic                  goto_ok;
    logic [11:0]           tgt_next;
    logic [11:0]           dist_cur;
    logic [11:0]           dist_new;
    logic                  within_cur;
    logic [5:0]            ramp_inc;
    logic [RECIP_W+5:0]    ramp_prod;
    logic [6:0]            ramp_duty;
    logic [1:0]            tries_inc;
    logic [1:0]            phase;
    logic                  brake;
    logic                  fail;
    t_state                nst;

    // target after this request and distances to old and new target
    assign goto_ok  = (i_req.req_type == REQ_GOTO) && (i_req.target_floor <= TOP_FLOOR);
    assign tgt_next = goto_ok ? i_cfg.floor_h[i_req.target_floor[1:0]] : i_state.target_height;
    assign dist_cur = (i_req.position_cm >= i_state.target_height)
                    ? (i_req.position_cm - i_state.target_height)
                    : (i_state.target_height - i_req.position_cm);
    assign dist_new = (i_req.position_cm >= tgt_next)
                    ? (i_req.position_cm - tgt_next)
                    : (tgt_next - i_req.position_cm);
    assign within_cur = (dist_cur <= {4'd0, i_cfg.tolerance});

    // ramp step
    assign ramp_inc  = i_state.ramp_count + 6'd1;
    assign ramp_prod = {{RECIP_W{1'b0}}, ramp_inc} * {6'd0, RECIP_M};
    assign ramp_duty = 7'(ramp_prod >> RECIP_SH);

    // saturating relevel counter
    assign tries_inc = (i_state.relevel_tries < TRIES_MAX)
                     ? (i_state.relevel_tries + 2'd1) : i_state.relevel_tries;

    // request decode
    always_comb begin
        nst   = i_state;
        phase = PHASE_NONE;
        brake = 1'b0;
        fail  = 1'b0;
        case (i_req.req_type)
            REQ_GOTO: begin
                if (goto_ok) begin
                    nst.target_height = tgt_next;
                    nst.ramp_count    = 6'd0;
                    nst.relevel_tries = 2'd0;
                    nst.armed         = 1'b1;
                end
            end
            REQ_STOP: begin
                nst.armed      = 1'b0;
                nst.ramp_count = 6'd0;
                brake          = 1'b1;
            end
            REQ_TICK: begin
                if (i_state.armed) begin
                    if (i_req.fault_present) begin
                        nst.armed      = 1'b0;
                        nst.ramp_count = 6'd0;
                        brake          = 1'b1;
                    end else if (within_cur) begin
                        brake              = 1'b1;
                        nst.last_duty      = DUTY_ZERO;
                        nst.last_direction = DIR_NONE;
                        nst.level_flag     = 1'b1;
                        nst.armed          = 1'b0;
                    end else begin
                        nst.level_flag     = 1'b0;
                        nst.last_direction = (i_req.position_cm < i_state.target_height)
                                           ? DIR_UP : DIR_DOWN;
                        if (dist_cur <= {4'd0, i_cfg.creep_band}) begin
                            nst.last_duty = DUTY_CREEP;
                            phase         = PHASE_LEVEL;
                        end else if (dist_cur <= {2'd0, i_cfg.slow_band}) begin
                            nst.last_duty = DUTY_SLOW;
                            phase         = PHASE_SLOWING;
                        end else begin
                            phase = PHASE_MOVING;
                            if (i_state.ramp_count < RAMP_LIM) begin
                                nst.ramp_count = ramp_inc;
                                nst.last_duty  = ramp_duty;
                            end else begin
                                nst.last_duty = DUTY_FULL;
                            end
                        end
                    end
                end
            end
            REQ_RELEVEL: begin
                if (!within_cur) begin
                    nst.relevel_tries = tries_inc;
                    if (tries_inc > TRIES_FAIL) begin
                        nst.armed      = 1'b0;
                        nst.ramp_count = 6'd0;
                        brake          = 1'b1;
                        fail           = 1'b1;
                    end else begin
                        nst.armed = 1'b1;
                    end
                end
            end
            default: nst = i_state;
        endcase
    end

    assign o_state = nst;

    // result item
    assign o_result.rejected      = (i_req.req_type == REQ_GOTO) && !goto_ok;
    assign o_result.duty_pct      = nst.last_duty;
    assign o_result.direction     = nst.last_direction;
    assign o_result.levelled      = nst.level_flag;
    assign o_result.phase         = phase;
    assign o_result.brake         = brake;
    assign o_result.level_fail    = fail;
    assign o_result.motion_active = nst.armed;
    assign o_result.at_target     = (dist_new <= {4'd0, i_cfg.tolerance});

endmodule
